@@ rtl/core/ring_fork_arbiter_core_assert.svh @@
// assertion macros for the ring fork arbiter
`ifndef RING_FORK_ARBITER_CORE_ASSERT_SVH
`define RING_FORK_ARBITER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// plain invariant checked on every rising clock edge outside reset
`define RFA_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// same-cycle implication checked outside reset
`define RFA_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define RFA_ASSERT(name, clk, rst_n, prop, msg)
`define RFA_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ rtl/core/rfa_pkg.sv @@
// shared types, constants and priority function of the ring fork arbiter
package rfa_pkg;

  localparam int unsigned SEAT_W    = 4;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned SEAT_CAP  = 16;
  localparam logic [CNT_W-1:0] CNT_RESET = 5'd5;

  // request codes
  typedef enum logic [1:0] {
    REQ_TAKE    = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_STOP    = 2'd2
  } rfa_req_e;

  // what a cell shows to its ring neighbors
  typedef struct packed {
    logic              hungry;
    logic              free;
    logic [TIME_W-1:0] wait_start;
    logic [SEAT_W-1:0] idx;
  } rfa_nbr_t;

  // per-cell commands from the sequencer
  typedef struct packed {
    logic req_set;
    logic req_clr;
    logic rel_set;
    logic take_clr;
    logic token_in;
  } rfa_cell_cmd_t;

  // controls shared by all cells
  typedef struct packed {
    logic              adv;
    logic              stop;
    logic [TIME_W-1:0] now_time;
  } rfa_ctl_t;

  // cell status back to the sequencer
  typedef struct packed {
    logic              token;
    logic              hungry;
    logic              free;
    logic [TIME_W-1:0] wait_start;
    logic              emit;
    logic              grant;
  } rfa_cell_st_t;

  // true when the neighbor has priority over this seat
  function automatic logic beats(rfa_nbr_t other, logic [TIME_W-1:0] self_wait,
                                 logic [SEAT_W-1:0] self_idx);
    logic res;
    if (!other.hungry) begin
      res = 1'b0;
    end else if (other.wait_start != self_wait) begin
      res = (other.wait_start < self_wait);
    end else if (other.idx[0] != self_idx[0]) begin
      res = !other.idx[0];
    end else begin
      res = (other.idx < self_idx);
    end
    return res;
  endfunction

endpackage

@@ rtl/core/rfa_if.sv @@
// valid/ready channels of the ring fork arbiter
interface rfa_req_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   req_type;
  logic [rfa_pkg::SEAT_W-1:0]   seat_id;
  logic [rfa_pkg::TIME_W-1:0]   now_time;
  modport source (output valid, req_type, seat_id, now_time, input ready);
  modport sink (input valid, req_type, seat_id, now_time, output ready);
endinterface

interface rfa_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [rfa_pkg::SEAT_W-1:0]   granted_seat;
  logic                         was_stopped;
  logic                         last_of_run;
  modport source (output valid, granted_seat, was_stopped, last_of_run, input ready);
  modport sink (input valid, granted_seat, was_stopped, last_of_run, output ready);
endinterface

interface rfa_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [rfa_pkg::CNT_W-1:0]    seat_count;
  modport source (output valid, seat_count, input ready);
  modport sink (input valid, seat_count, output ready);
endinterface

@@ rtl/core/rfa_cell.sv @@
// one seat of the ring: hunger, waiting start, its resource and the scan token
module rfa_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rfa_pkg::rfa_ctl_t            ctl_i,
  input  rfa_pkg::rfa_cell_cmd_t       cmd_i,
  input  logic [rfa_pkg::SEAT_W-1:0]   seat_idx_i,
  input  rfa_pkg::rfa_nbr_t            down_i,
  input  rfa_pkg::rfa_nbr_t            up_i,
  output rfa_pkg::rfa_cell_st_t        st_o
);

  logic                        token_q;
  logic                        hungry_q;
  logic                        free_q;
  logic [rfa_pkg::TIME_W-1:0]  wait_q;
  logic                        may_take;
  logic                        hit;
  logic                        emit;
  logic                        grant;

  // grant check for the seat holding the token
  assign may_take = free_q & up_i.free
                  & !rfa_pkg::beats(down_i, wait_q, seat_idx_i)
                  & !rfa_pkg::beats(up_i, wait_q, seat_idx_i);
  assign hit   = token_q & ctl_i.adv & hungry_q;
  assign emit  = hit & (ctl_i.stop | may_take);
  assign grant = hit & !ctl_i.stop & may_take;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      token_q  <= 1'b0;
      hungry_q <= 1'b0;
      free_q   <= 1'b1;
    end else begin
      if (ctl_i.adv) begin
        token_q <= cmd_i.token_in;
      end
      if (cmd_i.req_set) begin
        hungry_q <= 1'b1;
      end else if (cmd_i.req_clr || emit) begin
        hungry_q <= 1'b0;
      end
      if (cmd_i.rel_set) begin
        free_q <= 1'b1;
      end else if (grant || cmd_i.take_clr) begin
        free_q <= 1'b0;
      end
    end
  end

  // waiting start, written on a new request
  always_ff @(posedge clk_i) begin
    if (cmd_i.req_set) begin
      wait_q <= ctl_i.now_time;
    end
  end

  assign st_o.token      = token_q;
  assign st_o.hungry     = hungry_q;
  assign st_o.free       = free_q;
  assign st_o.wait_start = wait_q;
  assign st_o.emit       = emit;
  assign st_o.grant      = grant;

endmodule

@@ rtl/core/ring_fork_arbiter_core.sv @@
// top level of the ring fork arbiter: sequencer, result buffer and row of seat cells
//
// req_i takes one item (request, release or stop) when valid and ready are high.
// ready is high only while the block is idle between items.
// rsp_o gives one item per finished request: seat, stopped flag and a marker on
// the last item caused by the same input. An input may cause no item at all.
// cfg_i writes seat_count at any time it is valid; it is always ready and is
// meant to be written only while the block is idle.
// Sequence: an apply step, then a token walks the seat cells one per cycle while
// the output does not stall, then a close step ends the run. A new item is only
// accepted once the run has closed and the block is idle again.
// A result goes to a holding stage and moves into the output register when the next
// result arrives; the last one moves there at the close of the run.
// When the receiver stalls the scan holds: one result waits in the output
// register and one in a holding stage, and the token stops until room frees.
// Reset frees every resource, clears all pending seats and the stop state and
// sets seat_count to 5; no clearing pass is needed.
module ring_fork_arbiter_core #(
  parameter int unsigned MAX_SEATS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rfa_req_if.sink     req_i,
  rfa_rsp_if.source   rsp_o,
  rfa_cfg_if.sink     cfg_i
);

`include "ring_fork_arbiter_core_assert.svh"

  localparam int unsigned NumCells = (MAX_SEATS < rfa_pkg::SEAT_CAP) ? MAX_SEATS
                                                                      : rfa_pkg::SEAT_CAP;
  localparam int unsigned IdxW     = (NumCells > 1) ? $clog2(NumCells) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACT,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  state_e                         state_q;
  logic [rfa_pkg::CNT_W-1:0]      seat_count_q;
  logic [1:0]                     type_q;
  logic [rfa_pkg::SEAT_W-1:0]     seat_q;
  logic [rfa_pkg::TIME_W-1:0]     time_q;
  logic                           stopped_q;
  logic                           hold_valid_q;
  logic [rfa_pkg::SEAT_W-1:0]     hold_seat_q;
  logic                           hold_stop_q;
  logic                           out_valid_q;
  logic [rfa_pkg::SEAT_W-1:0]     out_seat_q;
  logic                           out_stop_q;
  logic                           out_last_q;

  logic [rfa_pkg::CNT_W-1:0]      n_seats;
  logic [IdxW-1:0]                n_last;
  logic                           out_free;
  logic                           adv;
  logic                           act_go;
  logic                           seat_ok;
  logic                           req_ok;
  logic                           rel_ok;
  logic                           act_ev;
  logic                           ev_valid;
  logic [rfa_pkg::SEAT_W-1:0]     ev_seat;
  logic [NumCells-1:0]            tok_vec;
  logic [NumCells-1:0]            emit_vec;
  logic [NumCells-1:0]            grant_vec;

  rfa_pkg::rfa_ctl_t              ctl;
  rfa_pkg::rfa_cell_st_t          st   [NumCells];
  rfa_pkg::rfa_nbr_t              nbr  [NumCells];
  rfa_pkg::rfa_nbr_t              down [NumCells];
  rfa_pkg::rfa_nbr_t              up   [NumCells];
  rfa_pkg::rfa_cell_cmd_t         cmd  [NumCells];

  // seats in use, clamped to the range 1 to the cell count
  always_comb begin
    if (seat_count_q == '0) begin
      n_seats = rfa_pkg::CNT_W'(1);
    end else if (seat_count_q > rfa_pkg::CNT_W'(NumCells)) begin
      n_seats = rfa_pkg::CNT_W'(NumCells);
    end else begin
      n_seats = seat_count_q;
    end
  end
  assign n_last = IdxW'(n_seats - rfa_pkg::CNT_W'(1));

  // handshake and apply-phase decode
  assign out_free = !out_valid_q || rsp_o.ready;
  assign adv      = !hold_valid_q || out_free;
  assign act_go   = (state_q == ST_ACT) && adv;
  assign seat_ok  = ({1'b0, seat_q} < n_seats);
  assign req_ok   = act_go && seat_ok && (type_q == rfa_pkg::REQ_TAKE);
  assign rel_ok   = act_go && seat_ok && (type_q == rfa_pkg::REQ_RELEASE);
  assign act_ev   = req_ok && stopped_q;

  assign ctl.adv      = adv;
  assign ctl.stop     = stopped_q;
  assign ctl.now_time = time_q;

  // row of seat cells with ring wiring
  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    logic in_rng;
    assign in_rng = (rfa_pkg::CNT_W'(i) < n_seats);

    assign nbr[i].hungry     = st[i].hungry;
    assign nbr[i].free       = st[i].free;
    assign nbr[i].wait_start = st[i].wait_start;
    assign nbr[i].idx        = rfa_pkg::SEAT_W'(i);

    if (i == 0) begin : g_first
      assign down[i]         = nbr[n_last];
      assign cmd[i].take_clr = in_rng && st[n_last].grant;
      assign cmd[i].token_in = (state_q == ST_ACT);
    end else begin : g_rest
      assign down[i]         = nbr[i-1];
      assign cmd[i].take_clr = in_rng && st[i-1].grant;
      assign cmd[i].token_in = in_rng && st[i-1].token;
    end

    if (i == NumCells - 1) begin : g_wrap
      assign up[i] = nbr[0];
    end else begin : g_next
      assign up[i] = (IdxW'(i) == n_last) ? nbr[0] : nbr[i+1];
    end

    assign cmd[i].req_set = req_ok && !stopped_q && (seat_q == rfa_pkg::SEAT_W'(i))
                          && !st[i].hungry;
    assign cmd[i].req_clr = req_ok && stopped_q && (seat_q == rfa_pkg::SEAT_W'(i));
    assign cmd[i].rel_set = rel_ok && in_rng
                          && ((seat_q == rfa_pkg::SEAT_W'(i)) || (seat_q == down[i].idx));

    assign tok_vec[i]   = st[i].token;
    assign emit_vec[i]  = st[i].emit;
    assign grant_vec[i] = st[i].grant;

    rfa_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .cmd_i      (cmd[i]),
      .seat_idx_i (rfa_pkg::SEAT_W'(i)),
      .down_i     (down[i]),
      .up_i       (up[i]),
      .st_o       (st[i])
    );
  end

  // seat of a result: apply phase uses the input seat, scan uses the token
  always_comb begin
    ev_seat = '0;
    if (state_q == ST_ACT) begin
      ev_seat = seat_q;
    end else begin
      for (int i = 0; i < NumCells; i++) begin
        if (tok_vec[i]) begin
          ev_seat = ev_seat | rfa_pkg::SEAT_W'(i);
        end
      end
    end
  end
  assign ev_valid = (act_go && act_ev) || (|emit_vec);

  // sequencer, holding stage and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      seat_count_q <= rfa_pkg::CNT_RESET;
      type_q       <= '0;
      seat_q       <= '0;
      time_q       <= '0;
      stopped_q    <= 1'b0;
      hold_valid_q <= 1'b0;
      hold_seat_q  <= '0;
      hold_stop_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      out_seat_q   <= '0;
      out_stop_q   <= 1'b0;
      out_last_q   <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        seat_count_q <= cfg_i.seat_count;
      end
      if (out_valid_q && rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      // a new result pushes the held one out as not last
      if (ev_valid) begin
        if (hold_valid_q) begin
          out_valid_q <= 1'b1;
          out_seat_q  <= hold_seat_q;
          out_stop_q  <= hold_stop_q;
          out_last_q  <= 1'b0;
        end
        hold_valid_q <= 1'b1;
        hold_seat_q  <= ev_seat;
        hold_stop_q  <= stopped_q;
      end
      case (state_q)
        ST_IDLE: begin
          if (req_i.valid) begin
            type_q  <= req_i.req_type;
            seat_q  <= req_i.seat_id;
            time_q  <= req_i.now_time;
            state_q <= ST_ACT;
          end
        end
        ST_ACT: begin
          if (adv) begin
            if (type_q == rfa_pkg::REQ_STOP) begin
              stopped_q <= 1'b1;
            end
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (adv && st[n_last].token) begin
            state_q <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (!hold_valid_q) begin
            state_q <= ST_IDLE;
          end else if (out_free) begin
            out_valid_q  <= 1'b1;
            out_seat_q   <= hold_seat_q;
            out_stop_q   <= hold_stop_q;
            out_last_q   <= 1'b1;
            hold_valid_q <= 1'b0;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // port drive
  assign req_i.ready        = (state_q == ST_IDLE);
  assign cfg_i.ready        = 1'b1;
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.granted_seat = out_seat_q;
  assign rsp_o.was_stopped  = out_stop_q;
  assign rsp_o.last_of_run  = out_last_q;

  // checks
  `RFA_ASSERT(a_token_onehot, clk_i, rst_ni, $onehot0(tok_vec), "more than one scan token")
  `RFA_ASSERT(a_one_grant, clk_i, rst_ni, $onehot0(grant_vec), "several grants in one cycle")
  `RFA_ASSERT_IMPL(a_scan_token, clk_i, rst_ni, state_q == ST_SCAN, tok_vec != '0, "scan lost its token")
  `RFA_ASSERT_IMPL(a_idle_empty, clk_i, rst_ni, state_q == ST_IDLE, !hold_valid_q, "result held while idle")

endmodule

@@ test/ring_fork_checker.sv @@
`timescale 1ns / 1ps
// checker for the ring fork arbiter: tracks seat state, predicts finished requests, compares
module ring_fork_checker
  import rfa_pkg::*;
#(
  parameter int unsigned MAX_SEATS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rfa_req_if          req_i,
  rfa_rsp_if          rsp_i,
  rfa_cfg_if          cfg_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned compared_o
);

  localparam int unsigned SEAT_LIM = (MAX_SEATS < SEAT_CAP) ? MAX_SEATS : SEAT_CAP;

  // one finished request as the block reports it
  typedef struct packed {
    logic [SEAT_W-1:0] seat;
    logic              stopped;
    logic              last;
  } finish_t;

  finish_t           finish_q[$];
  logic [SEAT_CAP-1:0] fork_free;
  logic [SEAT_CAP-1:0] hungry;
  logic [TIME_W-1:0] wait_t [SEAT_CAP];
  logic              halted;
  logic [CNT_W-1:0]  seat_cnt;
  int unsigned       fails;
  int unsigned       compared;

  // seats actually in use, count clamped to 1..limit
  function automatic int unsigned seats_used();
    int unsigned n;
    n = seat_cnt;
    if (n < 1) n = 1;
    if (n > SEAT_LIM) n = SEAT_LIM;
    return n;
  endfunction

  // neighbor wins when hungry and older; on a tie even seats, then the lower index
  function automatic logic outranks(int unsigned other, int unsigned self_s);
    logic res;
    if (!hungry[other]) begin
      res = 1'b0;
    end else if (wait_t[other] != wait_t[self_s]) begin
      res = (wait_t[other] < wait_t[self_s]);
    end else if (other[0] != self_s[0]) begin
      res = (other[0] == 1'b0);
    end else begin
      res = (other < self_s);
    end
    return res;
  endfunction

  // both forks free and no neighbor ahead
  function automatic logic can_eat(int unsigned s, int unsigned n);
    int unsigned up;
    int unsigned down;
    up = (s + 1) % n;
    down = (s == 0) ? n - 1 : s - 1;
    if (!fork_free[s] || !fork_free[up]) return 1'b0;
    return !outranks(down, s) && !outranks(up, s);
  endfunction

  function automatic void note_finish(int unsigned s, logic stopped);
    finish_t f;
    f.seat = s[SEAT_W-1:0];
    f.stopped = stopped;
    f.last = 1'b0;
    finish_q.push_back(f);
  endfunction

  // apply one item, then one ascending scan over the pending seats
  task automatic arbitrate(logic [1:0] kind, logic [SEAT_W-1:0] seat, logic [TIME_W-1:0] now);
    int unsigned n;
    int unsigned s_in;
    int unsigned first;
    n = seats_used();
    s_in = seat;
    first = finish_q.size();
    if (kind == REQ_TAKE && s_in < n) begin
      if (halted) begin
        hungry[s_in] = 1'b0;
        note_finish(s_in, 1'b1);
      end else if (!hungry[s_in]) begin
        wait_t[s_in] = now;
        hungry[s_in] = 1'b1;
      end
    end else if (kind == REQ_RELEASE && s_in < n) begin
      fork_free[s_in] = 1'b1;
      fork_free[(s_in + 1) % n] = 1'b1;
    end else if (kind == REQ_STOP) begin
      halted = 1'b1;
    end
    for (int unsigned s = 0; s < n; s++) begin
      if (hungry[s]) begin
        if (halted) begin
          hungry[s] = 1'b0;
          note_finish(s, 1'b1);
        end else if (can_eat(s, n)) begin
          fork_free[s] = 1'b0;
          fork_free[(s + 1) % n] = 1'b0;
          hungry[s] = 1'b0;
          note_finish(s, 1'b0);
        end
      end
    end
    if (finish_q.size() > first) finish_q[finish_q.size() - 1].last = 1'b1;
  endtask

  // watch all three channels; results are checked before a new item is applied
  always @(posedge clk_i or negedge rst_ni) begin
    finish_t got;
    finish_t want;
    if (!rst_ni) begin
      fork_free = '1;
      hungry = '0;
      halted = 1'b0;
      seat_cnt = CNT_RESET;
      for (int i = 0; i < SEAT_CAP; i++) wait_t[i] = '0;
      finish_q.delete();
      fails = 0;
      compared = 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        got.seat = rsp_i.granted_seat;
        got.stopped = rsp_i.was_stopped;
        got.last = rsp_i.last_of_run;
        compared++;
        if (finish_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected item, actual seat %0d stopped %0b last %0b",
                   $time, got.seat, got.stopped, got.last);
        end else begin
          want = finish_q.pop_front();
          if (got.seat !== want.seat || got.stopped !== want.stopped ||
              got.last !== want.last) begin
            fails++;
            $display("%0t: mismatch, expected seat %0d stopped %0b last %0b, actual seat %0d stopped %0b last %0b",
                     $time, want.seat, want.stopped, want.last, got.seat, got.stopped, got.last);
          end
        end
      end
      if (cfg_i.valid && cfg_i.ready) seat_cnt = cfg_i.seat_count;
      if (req_i.valid && req_i.ready) arbitrate(req_i.req_type, req_i.seat_id, req_i.now_time);
    end
    fail_count_o <= fails;
    pending_o <= finish_q.size();
    compared_o <= compared;
  end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// testbench top for the ring fork arbiter: clock, reset, stimulus, stalls and verdict
module tb_top;
  import rfa_pkg::*;

  localparam logic [1:0]  REQ_UNKNOWN   = 2'd3;
  localparam int unsigned IDLE_LIMIT    = 4000;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned PHASES        = 7;
  localparam int unsigned PHASE_ITEMS   = 50;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  int unsigned       fail_count;
  int unsigned       pending;
  int unsigned       compared;
  int unsigned       idle_cycles = 0;
  int unsigned       items_sent = 0;
  int unsigned       count_writes = 0;
  int unsigned       used = 5;
  int unsigned       stall_left = 0;
  logic              calm;
  logic [TIME_W-1:0] stamp;
  logic [SEAT_W-1:0] grant_q[$];
  logic [CNT_W-1:0]  phase_count [PHASES] = '{5'd16, 5'd2, 5'd11, 5'd24, 5'd3, 5'd13, 5'd7};

  rfa_req_if req ();
  rfa_rsp_if rsp ();
  rfa_cfg_if cfg ();

  ring_fork_arbiter_core DUT (
    .clk_i,
    .rst_ni,
    .req_i (req),
    .rsp_o (rsp),
    .cfg_i (cfg)
  );

  ring_fork_checker u_checker (
    .clk_i,
    .rst_ni,
    .req_i        (req),
    .rsp_i        (rsp),
    .cfg_i        (cfg),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .compared_o   (compared)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // receiver stalls in bursts of random length
  always @(posedge clk_i) begin
    if (calm) begin
      rsp.ready <= 1'b1;
    end else if (stall_left != 0) begin
      rsp.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      rsp.ready <= 1'b0;
      stall_left <= $urandom_range(0, 13);
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // remember granted seats so most releases hit a seat that holds its forks
  always @(posedge clk_i) begin
    if (rsp.valid && rsp.ready && !rsp.was_stopped) grant_q.push_back(rsp.granted_seat);
  end

  // watchdog on cycles with no handshake anywhere
  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("ring_fork_arbiter_core regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one item, with a random gap ahead of it outside the quiet stretch
  task automatic send_item(logic [1:0] kind, logic [SEAT_W-1:0] seat, logic [TIME_W-1:0] now);
    int unsigned gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.req_type <= kind;
    req.seat_id <= seat;
    req.now_time <= now;
    do @(posedge clk_i); while (!req.ready);
    items_sent++;
  endtask

  // hold the sender until every expected item is back, then let the block go idle
  task automatic drain();
    req.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_count(logic [CNT_W-1:0] value);
    drain();
    cfg.valid <= 1'b1;
    cfg.seat_count <= value;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    grant_q.delete();
    count_writes++;
    used = (value == 0) ? 1 : ((value > SEAT_CAP) ? SEAT_CAP : value);
  endtask

  // mostly requests and releases of live seats, some noise on any seat
  task automatic random_item();
    int unsigned pick;
    int unsigned idx;
    logic [SEAT_W-1:0] seat;
    logic [TIME_W-1:0] now;
    pick = $urandom_range(0, 99);
    // timestamps creep forward, with ties and fully random values mixed in
    case ($urandom_range(0, 9))
      0: now = $urandom();
      1: now = stamp;
      default: begin
        stamp = stamp + $urandom_range(1, 5);
        now = stamp;
      end
    endcase
    if (pick < 55) begin
      send_item(REQ_TAKE, SEAT_W'($urandom_range(0, used - 1)), now);
    end else if (pick < 62) begin
      send_item(pick[0] ? REQ_TAKE : REQ_RELEASE, SEAT_W'($urandom_range(0, 15)), now);
    end else if (pick < 97) begin
      if (grant_q.size() != 0 && $urandom_range(0, 4) != 0) begin
        idx = $urandom_range(0, grant_q.size() - 1);
        seat = grant_q[idx];
        grant_q.delete(idx);
      end else begin
        seat = SEAT_W'($urandom_range(0, used - 1));
      end
      send_item(REQ_RELEASE, seat, now);
    end else begin
      send_item(REQ_UNKNOWN, SEAT_W'($urandom_range(0, 15)), now);
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    req.valid <= 1'b0;
    req.req_type <= REQ_TAKE;
    req.seat_id <= '0;
    req.now_time <= '0;
    cfg.valid <= 1'b0;
    cfg.seat_count <= CNT_RESET;
    calm <= 1'b0;
    stamp = 32'd100;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // five seats after reset: oldest first, already hungry, odd/even tie
    send_item(REQ_TAKE, 4'd0, '0);
    send_item(REQ_TAKE, 4'd1, '1);
    send_item(REQ_TAKE, 4'd1, 32'd5);
    send_item(REQ_TAKE, 4'd2, '1);
    send_item(REQ_RELEASE, 4'd0, '0);
    send_item(REQ_RELEASE, 4'd2, '0);
    send_item(REQ_RELEASE, 4'd1, '0);
    // two even neighbors across the wrap with equal starts: lower index wins
    send_item(REQ_TAKE, 4'd1, 32'd10);
    send_item(REQ_TAKE, 4'd3, 32'd11);
    send_item(REQ_TAKE, 4'd0, 32'd20);
    send_item(REQ_TAKE, 4'd4, 32'd20);
    send_item(REQ_RELEASE, 4'd3, '0);
    send_item(REQ_RELEASE, 4'd1, '0);
    send_item(REQ_RELEASE, 4'd0, '0);
    send_item(REQ_RELEASE, 4'd4, '0);
    // seats beyond the count, the unused code, release without holding
    send_item(REQ_TAKE, 4'd15, '1);
    send_item(REQ_RELEASE, 4'd9, '0);
    send_item(REQ_UNKNOWN, 4'd2, '0);
    send_item(REQ_RELEASE, 4'd3, '0);

    // single seat shares one fork with itself; count 0 acts as 1
    write_count(5'd1);
    send_item(REQ_TAKE, 4'd0, 32'd30);
    send_item(REQ_TAKE, 4'd0, 32'd31);
    send_item(REQ_RELEASE, 4'd0, '0);
    write_count(5'd0);
    send_item(REQ_TAKE, 4'd0, 32'd40);
    send_item(REQ_RELEASE, 4'd0, '0);
    // count above the limit, wrap at seat 15, then leave seat 12 waiting above a lower count
    write_count(5'd31);
    send_item(REQ_TAKE, 4'd15, '1);
    send_item(REQ_TAKE, 4'd13, 32'd50);
    send_item(REQ_TAKE, 4'd12, 32'd51);
    write_count(5'd5);

    // random phases, each under its own seat count
    for (int p = 0; p < PHASES; p++) begin
      if (p != 0) write_count(phase_count[p]);
      else write_count(phase_count[0]);
      repeat (PHASE_ITEMS) random_item();
    end

    // quiet stretch at full ring, then stop with high seats left waiting
    write_count(5'd16);
    calm <= 1'b1;
    repeat (25) random_item();
    write_count(5'd10);
    send_item(REQ_STOP, 4'd0, '0);
    send_item(REQ_TAKE, 4'd3, stamp);
    send_item(REQ_RELEASE, 4'd3, stamp);
    send_item(REQ_STOP, 4'd7, stamp);
    send_item(REQ_TAKE, 4'd15, stamp);
    send_item(REQ_TAKE, 4'd0, '1);

    drain();
    $display("%0d items sent under %0d seat-count writes, %0d results compared",
             items_sent, count_writes, compared);
    $display("covered counts 0 to 31, ring wrap, start ties, lowered counts and stop");
    if (fail_count == 0 && pending == 0) begin
      $display("ring_fork_arbiter_core regression: pass");
    end else begin
      $display("ring_fork_arbiter_core regression: fail");
    end
    $finish;
  end

endmodule
